// File: rtl/assert_macros.svh
// Assertion macros shared by the text extractor RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define PDF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define PDF_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PDF_ASSERT(lbl, clk, rst_n, prop, msg)
`define PDF_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/pdf_txt_pkg.sv
// Package for the PDF text extractor: window size, character codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package pdf_txt_pkg;

	localparam int WINDOW_LEN = 15;
	localparam int IDX_W      = $clog2(WINDOW_LEN);
	localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

	localparam logic [15:0] INT_SAT   = 16'hFFFF;
	localparam logic [15:0] BIG_LIMIT = 16'd100;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_PR_LO  = 8'h20;
	localparam logic [7:0] CH_PR_HI  = 8'h7E;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SKIP,
		ST_RUN,
		ST_PARSE,
		ST_SCAN_END,
		ST_APPLY,
		ST_BT,
		ST_COMMIT
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic scan_load;
		logic scan_br;
		logic skip;
		logic run;
		logic parse;
		logic scan_end;
		logic apply;
		logic bt_check;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic td_hit;
		logic br_hit;
		logic skip_more;
		logic run_more;
		logic parse_more;
		logic scan_is_br;
		logic commit_ok;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/pdf_text_object_extractor.sv
// Top level of the PDF content-stream text extractor.
// Instantiates pdf_txt_ctrl and pdf_txt_dp; types from pdf_txt_pkg.
//
// Usage:
//   Byte channel: drive in_byte and restart with byte_valid; a transfer
//   happens at a clock edge with byte_valid high and byte_stall low.
//   restart clears the history window and text flags before that byte.
//   Char channel: out_char with last, under char_valid/char_stall. Each
//   byte gives zero, one or two characters; last marks the final one.
// Timing:
//   One byte at a time. A byte that starts no number scan passes through
//   accept, decide, apply, BT check and commit; a TD token or an opening
//   bracket adds a backward scan over the history window plus a forward
//   parse of the number, one window byte per cycle, and a byte can need
//   two scans. The scanner has a single window read port. Results appear
//   on the char channel the cycle after commit.
// Stalls:
//   A stalled result holds in a two-entry output buffer; the next byte is
//   still taken and processed; with results, it waits at commit for a drain.
// Reset: arst_n clears all state; the window fills with spaces.
`default_nettype none
module pdf_text_object_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] in_byte,
	input  logic       restart,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] out_char,
	output logic       last
);
	import pdf_txt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence each byte through the datapath.
	pdf_txt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Hold window, flags, scanner and output buffer.
	pdf_txt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.restart    (restart),
		.cmd        (cmd),
		.sts        (sts),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.last       (last)
	);

endmodule
`default_nettype wire

// File: rtl/pdf_txt_dp.sv
// Datapath of the PDF text extractor: history window, text flags, number
// scanner, result collection and output buffer. Uses pdf_txt_pkg.
`default_nettype none
`include "assert_macros.svh"
module pdf_txt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         in_byte,
	input  logic               restart,
	input  pdf_txt_pkg::cmd_t  cmd,
	output pdf_txt_pkg::sts_t  sts,
	output logic               char_valid,
	input  logic               char_stall,
	output logic [6:0]         out_char,
	output logic               last
);
	import pdf_txt_pkg::*;

	function automatic logic is_sep(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_CR) || (b == CH_LF);
	endfunction

	function automatic logic is_num(input logic [7:0] b);
		return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_DOT);
	endfunction

	logic [7:0]       win_q [WINDOW_LEN];
	logic [7:0]       c_q;
	logic             ito_q, inb_q, esc_q;
	logic [CNT_W-1:0] idx_q, q_q;
	logic             scan_br_q, any_q, dot_q, nz_q;
	logic [15:0]      v_q;
	logic [6:0]       pend_q [2];
	logic [1:0]       pcnt_q;
	logic [6:0]       obuf_q [2];
	logic [1:0]       ocnt_q;

	logic [7:0]  rd;
	logic        td_tok, et_tok, bt_tok;
	logic        td_hit, et_hit, br_hit, close_hit, in_text, esc_set, chr_emit;
	logic        skip_more, run_more, parse_more, scan_push;
	logic [19:0] v_mul;
	logic [15:0] v_sat;
	logic        push_en;
	logic [6:0]  push_char;
	logic        out_xfer;

	// Token positions: two token bytes with separators on both sides.
	assign td_tok = win_q[WINDOW_LEN-3] == CH_T && win_q[WINDOW_LEN-2] == CH_D &&
		is_sep(win_q[WINDOW_LEN-1]) && is_sep(win_q[WINDOW_LEN-4]);
	assign et_tok = win_q[WINDOW_LEN-3] == CH_E && win_q[WINDOW_LEN-2] == CH_T &&
		is_sep(win_q[WINDOW_LEN-1]) && is_sep(win_q[WINDOW_LEN-4]);
	assign bt_tok = win_q[WINDOW_LEN-3] == CH_B && win_q[WINDOW_LEN-2] == CH_T &&
		is_sep(win_q[WINDOW_LEN-1]) && is_sep(win_q[WINDOW_LEN-4]);

	assign td_hit    = ito_q && !inb_q && td_tok;
	assign et_hit    = ito_q && !inb_q && et_tok;
	assign br_hit    = ito_q && !et_hit && !inb_q && !esc_q && c_q == CH_LPAREN;
	assign close_hit = ito_q && inb_q && !esc_q && c_q == CH_RPAREN;
	assign in_text   = ito_q && inb_q && !close_hit;
	assign esc_set   = in_text && !esc_q && c_q == CH_BSLASH;
	assign chr_emit  = in_text && !esc_set && c_q >= CH_PR_LO && c_q <= CH_PR_HI;

	// Scanner read port: one window byte per cycle.
	assign rd = (idx_q < CNT_W'(WINDOW_LEN)) ? win_q[idx_q[IDX_W-1:0]] : CH_SPACE;

	assign skip_more  = (idx_q != '0) && rd == CH_SPACE;
	assign run_more   = (idx_q != '0) && is_num(rd);
	assign parse_more = (idx_q <= q_q) && !(rd == CH_DOT && dot_q);

	assign v_mul = ({4'b0, v_q} << 3) + ({4'b0, v_q} << 1) + {16'b0, rd[3:0]};
	assign v_sat = (v_mul > 20'(INT_SAT)) ? INT_SAT : v_mul[15:0];

	assign scan_push = scan_br_q ? (any_q && v_q > BIG_LIMIT)
		: !(any_q && v_q == 16'd1 && !nz_q);

	assign push_en   = (cmd.scan_end && scan_push) || (cmd.apply && (et_hit || chr_emit));
	assign push_char = (cmd.apply && !et_hit) ? c_q[6:0] : CH_SPACE[6:0];

	assign out_xfer = char_valid && !char_stall;

	assign sts.td_hit     = td_hit;
	assign sts.br_hit     = br_hit;
	assign sts.skip_more  = skip_more;
	assign sts.run_more   = run_more;
	assign sts.parse_more = parse_more;
	assign sts.scan_is_br = scan_br_q;
	assign sts.commit_ok  = (pcnt_q == 2'd0) || (ocnt_q == 2'd0);

	assign char_valid = ocnt_q != 2'd0;
	assign out_char   = obuf_q[0];
	assign last       = ocnt_q == 2'd1;

	// Window and text flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) win_q[i] <= CH_SPACE;
			ito_q <= 1'b0;
			inb_q <= 1'b0;
			esc_q <= 1'b0;
		end else if (cmd.accept && restart) begin
			for (int i = 0; i < WINDOW_LEN; i++) win_q[i] <= CH_SPACE;
			ito_q <= 1'b0;
			inb_q <= 1'b0;
			esc_q <= 1'b0;
		end else if (cmd.apply) begin
			if (et_hit) begin
				ito_q <= 1'b0;
			end else if (br_hit) begin
				inb_q <= 1'b1;
			end else if (close_hit) begin
				inb_q <= 1'b0;
			end else if (in_text) begin
				esc_q <= esc_set;
			end
			for (int i = 0; i < WINDOW_LEN - 1; i++) win_q[i] <= win_q[i+1];
			win_q[WINDOW_LEN-1] <= c_q;
		end else if (cmd.bt_check) begin
			if (!ito_q && bt_tok) ito_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) c_q <= in_byte;
	end

	// Number scanner: back over spaces, back over the run, then parse forward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			q_q       <= '0;
			scan_br_q <= 1'b0;
			any_q     <= 1'b0;
			dot_q     <= 1'b0;
			nz_q      <= 1'b0;
			v_q       <= '0;
		end else if (cmd.scan_load) begin
			idx_q     <= cmd.scan_br ? CNT_W'(WINDOW_LEN - 1) : CNT_W'(WINDOW_LEN - 5);
			scan_br_q <= cmd.scan_br;
			any_q     <= 1'b0;
			dot_q     <= 1'b0;
			nz_q      <= 1'b0;
			v_q       <= '0;
		end else if (cmd.skip) begin
			if (skip_more) idx_q <= idx_q - CNT_W'(1);
			else q_q <= idx_q;
		end else if (cmd.run) begin
			if (run_more) idx_q <= idx_q - CNT_W'(1);
			else idx_q <= idx_q + CNT_W'(1);
		end else if (cmd.parse && parse_more) begin
			idx_q <= idx_q + CNT_W'(1);
			if (rd == CH_DOT) begin
				dot_q <= 1'b1;
			end else begin
				any_q <= 1'b1;
				if (dot_q) nz_q <= nz_q | (rd != CH_ZERO);
				else v_q <= v_sat;
			end
		end
	end

	// Results of the current byte, collected before hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= 2'd0;
		end else if (cmd.accept) begin
			pcnt_q <= 2'd0;
		end else if (push_en) begin
			pcnt_q <= pcnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) pend_q[pcnt_q[0]] <= push_char;
	end

	// Output buffer: holds up to two results, oldest in slot 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 2'd0;
		end else if (cmd.commit && pcnt_q != 2'd0) begin
			ocnt_q <= pcnt_q;
		end else if (out_xfer) begin
			ocnt_q <= ocnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && pcnt_q != 2'd0) begin
			obuf_q[0] <= pend_q[0];
			obuf_q[1] <= pend_q[1];
		end else if (out_xfer) begin
			obuf_q[0] <= obuf_q[1];
		end
	end

	`PDF_NEVER(a_pend_ovf, clk, arst_n, push_en && pcnt_q == 2'd2, "result overflow")
	`PDF_ASSERT(a_commit_free, clk, arst_n, (cmd.commit && pcnt_q != 2'd0) |-> ocnt_q == 2'd0, "commit over pending output")
	`PDF_NEVER(a_ocnt_range, clk, arst_n, ocnt_q == 2'd3, "output count out of range")
	`PDF_ASSERT(a_parse_idx, clk, arst_n, cmd.parse |-> idx_q <= q_q + CNT_W'(1), "parse index past run")

endmodule
`default_nettype wire

// File: rtl/pdf_txt_ctrl.sv
// Controller of the PDF text extractor: sequences one byte through
// decide, number scans, state update and hand-off. Uses pdf_txt_pkg.
`default_nettype none
module pdf_txt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  pdf_txt_pkg::sts_t sts,
	output pdf_txt_pkg::cmd_t cmd
);
	import pdf_txt_pkg::*;

	ctl_state_t state_q, state_d;
	logic       chain_br;

	// A bracket scan follows a TD scan on the same byte.
	assign chain_br = !sts.scan_is_br && sts.br_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (byte_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.td_hit || sts.br_hit) state_d = ST_SKIP;
				else state_d = ST_APPLY;
			end
			ST_SKIP: begin
				if (!sts.skip_more) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (!sts.run_more) state_d = ST_PARSE;
			end
			ST_PARSE: begin
				if (!sts.parse_more) state_d = ST_SCAN_END;
			end
			ST_SCAN_END: begin
				if (chain_br) state_d = ST_SKIP;
				else state_d = ST_APPLY;
			end
			ST_APPLY:  state_d = ST_BT;
			ST_BT:     state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (sts.commit_ok) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		byte_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				byte_stall = 1'b0;
				cmd.accept = byte_valid;
			end
			ST_DECIDE: begin
				cmd.scan_load = sts.td_hit || sts.br_hit;
				cmd.scan_br   = !sts.td_hit;
			end
			ST_SKIP:  cmd.skip  = 1'b1;
			ST_RUN:   cmd.run   = 1'b1;
			ST_PARSE: cmd.parse = 1'b1;
			ST_SCAN_END: begin
				cmd.scan_end  = 1'b1;
				cmd.scan_load = chain_br;
				cmd.scan_br   = 1'b1;
			end
			ST_APPLY:  cmd.apply    = 1'b1;
			ST_BT:     cmd.bt_check = 1'b1;
			ST_COMMIT: cmd.commit   = sts.commit_ok;
			default: begin
				cmd        = '0;
				byte_stall = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire
